/* sv/tvu_pkg.sv */
// Shared types and constants for the triangle tangent vector unit.
// Used by the front, the job queue and the back; depends on nothing.
package tvu_pkg;

	localparam int COORD_W  = 32;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int IDX_W    = 16;
	localparam int TAN_W    = 16;
	localparam int PROD_W   = 2 * DIFF_W;
	localparam int ACC_W    = PROD_W + 1;
	localparam int MAG_W    = PROD_W;
	localparam int NORM_W   = 30;
	localparam int SUM_W    = 64;
	localparam int LEN_W    = 32;
	localparam int FRAC_W   = 14;
	localparam int REM_W    = NORM_W + FRAC_W + 2;
	localparam int DIV_W    = LEN_W + TAN_W - 1;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int IN_W     = IDX_W + 5 * COORD_W;
	localparam int OUT_W    = IDX_W + 3 * TAN_W;
	localparam logic [TAN_W-1:0] ONE_Q14 = TAN_W'(1 << FRAC_W);

	// edges, UV deltas and corner indexes of one triangle
	typedef struct packed {
		logic [IDX_W-1:0]         idx0;
		logic [IDX_W-1:0]         idx1;
		logic [IDX_W-1:0]         idx2;
		logic signed [DIFF_W-1:0] e1x;
		logic signed [DIFF_W-1:0] e1y;
		logic signed [DIFF_W-1:0] e1z;
		logic signed [DIFF_W-1:0] e2x;
		logic signed [DIFF_W-1:0] e2y;
		logic signed [DIFF_W-1:0] e2z;
		logic signed [DIFF_W-1:0] du1;
		logic signed [DIFF_W-1:0] dv1;
		logic signed [DIFF_W-1:0] du2;
		logic signed [DIFF_W-1:0] dv2;
	} job_t;

endpackage

/* sv/triangle_tangent_vector_unit.sv */
// Triangle tangent vector unit. Vertices enter one per request in triangle order
// (index, position and UV in signed Q16.16); on every third vertex the unit emits three
// results, one per corner index in arrival order, each with the unit tangent in signed
// Q1.14, degenerate on tuser and tlast on the third. The intake takes a vertex every
// cycle, but the third corner waits while the two-entry job queue is full; a triangle
// then occupies the sequencer, one triangle at a time, through taking the job, multiply,
// sign, normalize, square, square root steps, division and output, paced by the single
// shared multiplier and the bit-per-cycle root and divide. Degenerate triangles skip
// from sign to output.
// Depends on tvu_pkg, tvu_front, tvu_queue and tvu_back.
module triangle_tangent_vector_unit import tvu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// vertex_index[15:0], pos_x[47:16], pos_y[79:48], pos_z[111:80], tex_u[143:112],
	// tex_v[175:144]
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// corner_index[15:0], tan_x[31:16], tan_y[47:32], tan_z[63:48]
	output logic [OUT_W-1:0] m_tdata,
	// last_of_triangle
	output logic             m_tlast,
	// degenerate
	output logic             m_tuser
);

	logic q_full, push, pop, job_valid;
	job_t job_in, job_out;

	tvu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.job      (job_in)
	);

	tvu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.job_in    (job_in),
		.full      (q_full),
		.pop       (pop),
		.job_valid (job_valid),
		.job_out   (job_out)
	);

	tvu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_out),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

/* sv/tvu_front.sv */
// Vertex intake: holds the first two corners and forms edges and UV deltas on the third.
// Depends on tvu_pkg.
module tvu_front import tvu_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	// vertex_index[15:0], pos_x, pos_y, pos_z, tex_u, tex_v (32 each) from bit 16 up
	input  logic [IN_W-1:0] s_tdata,
	input  logic            q_full,
	output logic            push,
	output job_t            job
);

	logic [1:0]         cnt_q;
	logic [COORD_W-1:0] hx_q [2];
	logic [COORD_W-1:0] hy_q [2];
	logic [COORD_W-1:0] hz_q [2];
	logic [COORD_W-1:0] hu_q [2];
	logic [COORD_W-1:0] hv_q [2];
	logic [IDX_W-1:0]   hi_q [2];
	logic [IDX_W-1:0]   in_idx;
	logic [COORD_W-1:0] in_x, in_y, in_z, in_u, in_v;
	logic               accept, third;

	function automatic logic [DIFF_W-1:0] sdiff(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
		return {a[COORD_W-1], a} - {b[COORD_W-1], b};
	endfunction

	assign in_idx = s_tdata[IDX_W-1:0];
	assign in_x   = s_tdata[IDX_W +: COORD_W];
	assign in_y   = s_tdata[IDX_W + COORD_W +: COORD_W];
	assign in_z   = s_tdata[IDX_W + 2 * COORD_W +: COORD_W];
	assign in_u   = s_tdata[IDX_W + 3 * COORD_W +: COORD_W];
	assign in_v   = s_tdata[IDX_W + 4 * COORD_W +: COORD_W];

	assign third    = (cnt_q == 2'd2);
	assign s_tready = !third || !q_full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && third;

	always_comb begin
		job.idx0 = hi_q[0];
		job.idx1 = hi_q[1];
		job.idx2 = in_idx;
		job.e1x  = sdiff(hx_q[1], hx_q[0]);
		job.e1y  = sdiff(hy_q[1], hy_q[0]);
		job.e1z  = sdiff(hz_q[1], hz_q[0]);
		job.e2x  = sdiff(in_x, hx_q[0]);
		job.e2y  = sdiff(in_y, hy_q[0]);
		job.e2z  = sdiff(in_z, hz_q[0]);
		job.du1  = sdiff(hu_q[1], hu_q[0]);
		job.dv1  = sdiff(hv_q[1], hv_q[0]);
		job.du2  = sdiff(in_u, hu_q[0]);
		job.dv2  = sdiff(in_v, hv_q[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= third ? 2'd0 : cnt_q + 2'd1;
		end
	end

	// hold corners 0 and 1
	always_ff @(posedge clk) begin
		if (accept && !third) begin
			hx_q[cnt_q[0]] <= in_x;
			hy_q[cnt_q[0]] <= in_y;
			hz_q[cnt_q[0]] <= in_z;
			hu_q[cnt_q[0]] <= in_u;
			hv_q[cnt_q[0]] <= in_v;
			hi_q[cnt_q[0]] <= in_idx;
		end
	end

endmodule

/* sv/tvu_queue.sv */
// Short job queue between the vertex intake and the tangent sequencer.
// Depends on tvu_pkg.
module tvu_queue import tvu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t job_in,
	output logic full,
	input  logic pop,
	output logic job_valid,
	output job_t job_out
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full      = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign job_valid = (cnt_q != '0);
	assign job_out   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop)  rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= job_in;
	end

endmodule

/* sv/tvu_back.sv */
// Tangent sequencer: products on one shared multiplier, normalize, square root,
// division, then three results per triangle. Depends on tvu_pkg.
module tvu_back import tvu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  job_t             job,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	// corner_index[15:0], tan_x[31:16], tan_y[47:32], tan_z[63:48]
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tlast,
	// degenerate
	output logic             m_tuser
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL  = 8'b0000_0010,
		ST_SIGN = 8'b0000_0100,
		ST_NORM = 8'b0000_1000,
		ST_SQ   = 8'b0001_0000,
		ST_SQRT = 8'b0010_0000,
		ST_DIV  = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} state_t;

	state_t                   state_q;
	logic [4:0]               step_q;
	logic [1:0]               comp_q;
	job_t                     job_q;
	logic signed [PROD_W-1:0] prod_q, first_q, mul_p;
	logic signed [DIFF_W-1:0] mul_a, mul_b;
	logic signed [ACC_W-1:0]  d_q [4];
	logic [MAG_W-1:0]         mag_q [3];
	logic                     neg_q [3];
	logic                     degen_q;
	logic [SUM_W-1:0]         sum_q, rn_q, res_q;
	logic [REM_W-1:0]         rem_q;
	logic [DIV_W-1:0]         dv_q;
	logic [TAN_W-1:0]         quo_q;
	logic [TAN_W-1:0]         tan_q [3];

	logic [4:0]               kk;
	logic [MAG_W-1:0]         abs_t [3];
	logic                     neg_t [3];
	logic                     degen_nx;
	logic [MAG_W-1:0]         mag_or;
	logic                     over, under;
	logic [SUM_W-1:0]         bitv, trial;
	logic                     sq_ge;
	logic                     dv_ge;
	logic [TAN_W-1:0]         quo_nx, cap, tan_nx;
	logic [NORM_W-1:0]        sq_op;
	logic [IDX_W-1:0]         out_idx;

	assign pop = (state_q == ST_IDLE) && job_valid;
	assign kk  = step_q - 5'd1;

	// shared multiplier operand select
	always_comb begin
		unique case (step_q[1:0])
			2'd0:    sq_op = mag_q[0][NORM_W-1:0];
			2'd1:    sq_op = mag_q[1][NORM_W-1:0];
			default: sq_op = mag_q[2][NORM_W-1:0];
		endcase
		if (state_q == ST_SQ) begin
			mul_a = signed'({(DIFF_W-NORM_W)'(0), sq_op});
			mul_b = mul_a;
		end else begin
			unique case (step_q[2:0])
				3'd0: begin mul_a = job_q.du1; mul_b = job_q.dv2; end
				3'd1: begin mul_a = job_q.du2; mul_b = job_q.dv1; end
				3'd2: begin mul_a = job_q.dv2; mul_b = job_q.e1x; end
				3'd3: begin mul_a = job_q.dv1; mul_b = job_q.e2x; end
				3'd4: begin mul_a = job_q.dv2; mul_b = job_q.e1y; end
				3'd5: begin mul_a = job_q.dv1; mul_b = job_q.e2y; end
				3'd6: begin mul_a = job_q.dv2; mul_b = job_q.e1z; end
				default: begin mul_a = job_q.dv1; mul_b = job_q.e2z; end
			endcase
		end
	end
	assign mul_p = mul_a * mul_b;

	// magnitudes and signs, with the determinant sign folded in
	always_comb begin
		logic signed [ACC_W-1:0] t;
		logic [ACC_W-1:0]        a;
		degen_nx = (d_q[0] == '0);
		for (int i = 0; i < 3; i++) begin
			t        = d_q[i+1];
			a        = t[ACC_W-1] ? ACC_W'(-t) : ACC_W'(t);
			abs_t[i] = a[MAG_W-1:0];
			neg_t[i] = t[ACC_W-1] ^ d_q[0][ACC_W-1];
		end
		if (d_q[1] == '0 && d_q[2] == '0 && d_q[3] == '0) degen_nx = 1'b1;
	end

	assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];
	assign over   = |mag_or[MAG_W-1:NORM_W];
	assign under  = !mag_or[NORM_W-1];

	assign bitv  = SUM_W'(1) << {step_q, 1'b0};
	assign trial = res_q + bitv;
	assign sq_ge = (rn_q >= trial);

	assign dv_ge  = ({1'b0, rem_q} >= dv_q);
	assign quo_nx = {quo_q[TAN_W-2:0], dv_ge};
	assign cap    = (quo_nx > ONE_Q14) ? ONE_Q14 : quo_nx;
	assign tan_nx = neg_q[comp_q] ? TAN_W'(-cap) : cap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			comp_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_MUL;
						step_q  <= '0;
					end
				end
				ST_MUL: begin
					if (step_q == 5'd8) state_q <= ST_SIGN;
					else step_q <= step_q + 5'd1;
				end
				ST_SIGN: begin
					state_q <= degen_nx ? ST_EMIT : ST_NORM;
					step_q  <= '0;
				end
				ST_NORM: begin
					if (!over && !under) state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (step_q == 5'd3) begin
						state_q <= ST_SQRT;
						step_q  <= 5'd31;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_SQRT: begin
					if (step_q == 5'd0) begin
						state_q <= ST_DIV;
						comp_q  <= '0;
					end else begin
						step_q <= step_q - 5'd1;
					end
				end
				ST_DIV: begin
					if (step_q == 5'd16) begin
						step_q <= '0;
						if (comp_q == 2'd2) state_q <= ST_EMIT;
						else comp_q <= comp_q + 2'd1;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						if (step_q == 5'd2) state_q <= ST_IDLE;
						else step_q <= step_q + 5'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) job_q <= job;
			end
			ST_MUL: begin
				if (step_q != 5'd8) prod_q <= mul_p;
				if (step_q != 5'd0) begin
					if (!kk[0]) first_q <= prod_q;
					else d_q[kk[2:1]] <= ACC_W'(first_q) - ACC_W'(prod_q);
				end
			end
			ST_SIGN: begin
				degen_q <= degen_nx;
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= abs_t[i];
					neg_q[i] <= neg_t[i];
					tan_q[i] <= '0;
				end
				sum_q <= '0;
			end
			ST_NORM: begin
				// one common shift for all three, one bit a cycle
				for (int i = 0; i < 3; i++) begin
					if (over) mag_q[i] <= mag_q[i] >> 1;
					else if (under) mag_q[i] <= mag_q[i] << 1;
				end
			end
			ST_SQ: begin
				if (step_q != 5'd3) prod_q <= mul_p;
				if (step_q != 5'd0) sum_q <= sum_q + SUM_W'(prod_q[2*NORM_W-1:0]);
				rn_q  <= sum_q + ((step_q != 5'd0) ? SUM_W'(prod_q[2*NORM_W-1:0]) : '0);
				res_q <= '0;
			end
			ST_SQRT: begin
				if (sq_ge) begin
					rn_q  <= rn_q - trial;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			ST_DIV: begin
				if (step_q == 5'd0) begin
					rem_q <= REM_W'({mag_q[comp_q][NORM_W-1:0], FRAC_W'(0)})
						+ REM_W'(res_q[LEN_W-1:1]);
					dv_q  <= {res_q[LEN_W-1:0], (TAN_W-1)'(0)};
					quo_q <= '0;
				end else begin
					if (dv_ge) rem_q <= rem_q - dv_q[REM_W-1:0];
					dv_q  <= dv_q >> 1;
					quo_q <= quo_nx;
					if (step_q == 5'd16) tan_q[comp_q] <= tan_nx;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		unique case (step_q[1:0])
			2'd0:    out_idx = job_q.idx0;
			2'd1:    out_idx = job_q.idx1;
			default: out_idx = job_q.idx2;
		endcase
	end

	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata  = {tan_q[2], tan_q[1], tan_q[0], out_idx};
	assign m_tlast  = (step_q == 5'd2);
	assign m_tuser  = degen_q;

`ifndef NO_ASSERTIONS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[OUT_W-1:IDX_W] == '0)
		else $error("degenerate result carries a nonzero tangent");
	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQ |-> mag_or[MAG_W-1:NORM_W] == '0 && mag_or[NORM_W-1])
		else $error("normalize left the largest magnitude off 30 bits");
	a_tan_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(tan_q[0]) >= -$signed(ONE_Q14)
			&& $signed(tan_q[0]) <= $signed(ONE_Q14))
		else $error("tangent x out of unit range");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_MUL && step_q == 5'd0)
		else $error("job taken outside idle");
`endif

endmodule

/* bench/tb_top.sv */
// Testbench for triangle_tangent_vector_unit: streams vertices, predicts tangents per triangle
// and checks every corner result in order. Depends on tvu_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb_top;
	import tvu_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [IDX_W-1:0] corner;
		logic [TAN_W-1:0] tx;
		logic [TAN_W-1:0] ty;
		logic [TAN_W-1:0] tz;
		logic             degen;
		logic             last;
	} tangent_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tlast;
	logic             m_tuser;

	tangent_t  tangent_q[$];
	int        fail_count = 0;
	int        idle_cycles = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	bit        recv_hold = 1'b0;
	int        hold_cycles = 0;
	int        corner_cnt = 0;
	logic [IDX_W-1:0]       held_idx [2];
	logic signed [COORD_W-1:0] held_c [2][5];

	triangle_tangent_vector_unit DUT (.*);

	always #1 clk = ~clk;

	function automatic int bit_len(logic [DIFF_W*2:0] v);
		for (int i = DIFF_W*2; i >= 0; i--)
			if (v[i]) return i + 1;
		return 0;
	endfunction

	function automatic logic [31:0] int_sqrt(logic [63:0] n);
		logic [63:0] root;
		logic [63:0] rem;
		logic [63:0] b;
		root = 0;
		rem = n;
		b = 64'd1 << 62;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root[31:0];
	endfunction

	// Take one vertex; on the third corner push the three expected tangents.
	task automatic predict_tangents(logic [IN_W-1:0] d);
		logic [IDX_W-1:0] idx;
		logic signed [COORD_W-1:0] c [5];
		logic signed [DIFF_W:0] e1 [3];
		logic signed [DIFF_W:0] e2 [3];
		logic signed [DIFF_W:0] du1, dv1, du2, dv2;
		logic signed [2*DIFF_W+2:0] det;
		logic signed [2*DIFF_W+2:0] t [3];
		logic [2*DIFF_W:0] mag [3];
		logic [63:0] m [3];
		logic [63:0] sum;
		logic [63:0] len;
		logic [63:0] q;
		logic [TAN_W-1:0] tb [3];
		logic [IDX_W-1:0] ids [3];
		logic degen;
		int maxlen;
		tangent_t r;
		idx = d[IDX_W-1:0];
		for (int i = 0; i < 5; i++) c[i] = d[IDX_W + i*COORD_W +: COORD_W];
		if (corner_cnt < 2) begin
			held_idx[corner_cnt] = idx;
			for (int i = 0; i < 5; i++) held_c[corner_cnt][i] = c[i];
			corner_cnt++;
			return;
		end
		corner_cnt = 0;
		for (int i = 0; i < 3; i++) begin
			e1[i] = held_c[1][i] - held_c[0][i];
			e2[i] = c[i] - held_c[0][i];
		end
		du1 = held_c[1][3] - held_c[0][3];
		dv1 = held_c[1][4] - held_c[0][4];
		du2 = c[3] - held_c[0][3];
		dv2 = c[4] - held_c[0][4];
		det = du1 * dv2 - du2 * dv1;
		maxlen = 0;
		for (int i = 0; i < 3; i++) begin
			t[i] = dv2 * e1[i] - dv1 * e2[i];
			if (det < 0) t[i] = -t[i];
			mag[i] = (2*DIFF_W+1)'(t[i] < 0 ? -t[i] : t[i]);
			if (bit_len(mag[i]) > maxlen) maxlen = bit_len(mag[i]);
		end
		degen = (det == 0) || (maxlen == 0);
		for (int i = 0; i < 3; i++) tb[i] = '0;
		if (!degen) begin
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				if (maxlen >= NORM_W) m[i] = 64'(mag[i] >> (maxlen - NORM_W));
				else m[i] = 64'(mag[i] << (NORM_W - maxlen));
				sum = sum + m[i] * m[i];
			end
			len = 64'(int_sqrt(sum));
			for (int i = 0; i < 3; i++) begin
				q = (m[i] * 64'd16384 + len / 2) / len;
				if (q > 64'd16384) q = 64'd16384;
				tb[i] = t[i] < 0 ? TAN_W'(-q) : TAN_W'(q);
			end
		end
		ids[0] = held_idx[0];
		ids[1] = held_idx[1];
		ids[2] = idx;
		for (int k = 0; k < 3; k++) begin
			r = '{ids[k], tb[0], tb[1], tb[2], degen, k == 2};
			tangent_q.push_back(r);
		end
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		fail_count++;
	endtask

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		tangent_t want;
		if (m_tvalid && m_tready) begin
			if (tangent_q.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 0);
			end else begin
				want = tangent_q.pop_front();
				if (m_tdata[15:0] != want.corner) report_mismatch("corner", m_tdata[15:0], want.corner);
				if (m_tdata[31:16] != want.tx) report_mismatch("tan_x", m_tdata[31:16], want.tx);
				if (m_tdata[47:32] != want.ty) report_mismatch("tan_y", m_tdata[47:32], want.ty);
				if (m_tdata[63:48] != want.tz) report_mismatch("tan_z", m_tdata[63:48], want.tz);
				if (m_tuser != want.degen) report_mismatch("degenerate", m_tuser, want.degen);
				if (m_tlast != want.last) report_mismatch("last", m_tlast, want.last);
			end
		end
	end

	// Receiver stall: random, or a long counted hold-off.
	always @(posedge clk) begin
		if (recv_hold) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Hold tvalid across back-to-back requests; drop it only in idle cycles.
	task automatic send_vertex(logic [IN_W-1:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_tangents(d);
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(16)) - 8) << 16;
			3: return 32'($signed($urandom_range(4)) - 2);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [IN_W-1:0] make_vertex(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] x,
		logic [COORD_W-1:0] y, logic [COORD_W-1:0] z, logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
		return {v, u, z, y, x, idx};
	endfunction

	task automatic send_triangle(logic [COORD_W-1:0] p [3][5]);
		for (int k = 0; k < 3; k++)
			send_vertex(make_vertex(IDX_W'($urandom), p[k][0], p[k][1], p[k][2], p[k][3],
				p[k][4]));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tangent_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		logic [COORD_W-1:0] p [3][5];
		// plain right triangle, unit UVs
		p = '{'{0, 0, 0, 0, 0}, '{32'h10000, 0, 0, 32'h10000, 0},
			'{0, 32'h10000, 0, 0, 32'h10000}};
		send_triangle(p);
		// flipped UV winding
		p = '{'{0, 0, 0, 0, 0}, '{32'h10000, 0, 0, 0, 32'h10000},
			'{0, 32'h10000, 0, 32'h10000, 0}};
		send_triangle(p);
		// zero determinant
		p = '{'{5, 6, 7, 0, 0}, '{9, 1, 2, 32'h10000, 32'h10000},
			'{3, 3, 3, 32'h20000, 32'h20000}};
		send_triangle(p);
		// zero tangent: all positions equal
		p = '{'{1, 1, 1, 0, 0}, '{1, 1, 1, 32'h10000, 0}, '{1, 1, 1, 0, 32'h10000}};
		send_triangle(p);
		// field extremes
		p = '{'{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff},
			'{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000},
			'{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000}};
		send_vertex(make_vertex(16'hffff, p[0][0], p[0][1], p[0][2], p[0][3], p[0][4]));
		send_vertex(make_vertex(16'h0000, p[1][0], p[1][1], p[1][2], p[1][3], p[1][4]));
		send_vertex(make_vertex(16'hffff, p[2][0], p[2][1], p[2][2], p[2][3], p[2][4]));
		// tiny magnitudes force left shifts in normalize
		p = '{'{0, 0, 0, 0, 0}, '{1, 0, 0, 1, 0}, '{0, 1, 1, 0, 1}};
		send_triangle(p);
		wait_drained();
	endtask

	task automatic test_random(int triangles);
		logic [COORD_W-1:0] p [3][5];
		for (int n = 0; n < triangles; n++) begin
			for (int k = 0; k < 3; k++)
				for (int i = 0; i < 5; i++) p[k][i] = rand_coord();
			send_triangle(p);
		end
	endtask

	task automatic test_backpressure();
		logic [COORD_W-1:0] p [3][5];
		recv_hold = 1'b1;
		fork
			begin
				hold_cycles = 0;
				while (hold_cycles < 1500) begin
					@(posedge clk);
					hold_cycles++;
				end
				recv_hold = 1'b0;
			end
			for (int n = 0; n < 4; n++) begin
				for (int k = 0; k < 3; k++)
					for (int i = 0; i < 5; i++) p[k][i] = $urandom;
				send_triangle(p);
			end
		join
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(4);
		send_idle_pct = 58;
		test_random(5);
		send_idle_pct = 0;
		recv_stall_pct = 58;
		test_random(5);
		send_idle_pct = 17;
		recv_stall_pct = 17;
		test_random(5);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_drained();
		test_backpressure();
		test_random(4);
		wait_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && tangent_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
